/* rtl/core/neural_activation_unit_top_assert.svh */
// Assertion macros shared by the activation unit files.
// Define NO_ASSERTIONS to compile the checks away.
`ifndef NEURAL_ACTIVATION_UNIT_TOP_ASSERT_SVH
`define NEURAL_ACTIVATION_UNIT_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge outside reset.
`define NAU_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define NAU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define NAU_ASSERT(label, clk, rst, prop, msg)
`define NAU_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* rtl/core/nau_pkg.sv */
`timescale 1ns / 1ps

package nau_pkg;

   // Sample format: signed Q4.12.
   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 12;
   localparam int DIFF_W     = DATA_WIDTH + 1;
   localparam int MUL_W      = 2 * DIFF_W;
   localparam int LEAK_W     = 2 * DATA_WIDTH;

   localparam int TABLE_DEPTH_DEFAULT = 64;

   // Configuration register file.
   localparam int MODE_WIDTH      = 2;
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODE       = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LEAK_SLOPE = 4'd1;

   localparam logic [MODE_WIDTH-1:0] MODE_RELU    = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_LEAKY   = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_SIGMOID = 2'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_TANH    = 2'd3;

   localparam logic [MODE_WIDTH-1:0]        MODE_RESET       = MODE_RELU;
   localparam logic signed [DATA_WIDTH-1:0] LEAK_SLOPE_RESET = 16'sd41;

   localparam logic signed [DATA_WIDTH-1:0] ACT_MAX = 16'sh7FFF;
   localparam logic signed [DATA_WIDTH-1:0] ACT_MIN = 16'sh8000;

   // Sigmoid output upper bound, 1.0 in Q4.12.
   localparam logic signed [DATA_WIDTH-1:0] SIG_ONE = 16'sd4096;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] sample;
      logic                         last_in;
   } nau_req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] activated;
      logic                         last_out;
   } nau_rsp_type;

   // Payload handed from the lookup half to the interpolation half.
   typedef struct packed {
      logic [MODE_WIDTH-1:0]        mode;
      logic                         last;
      logic signed [DATA_WIDTH-1:0] x;
      logic signed [DATA_WIDTH-1:0] t0;
      logic signed [DIFF_W-1:0]     diff;
      logic [DATA_WIDTH-1:0]        rem;
      logic signed [LEAK_W-1:0]     leak_prod;
   } nau_mid_type;

   // ----------------------------------------------------------------
   // Table construction, evaluated at elaboration only. All arithmetic
   // is Q60 unsigned fixed point so the entries come out bit exact.
   // ----------------------------------------------------------------
   localparam int          Q_FRAC = 60;
   localparam logic [63:0] ONE_Q  = 64'd1 << Q_FRAC;

   // Restoring division, one quotient bit per step.
   function automatic logic [63:0] nau_udiv(input logic [63:0] num,
                                             input logic [63:0] den);
      logic [64:0] r;
      logic [63:0] q;
      r = '0;
      q = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[63:0], num[i]};
         if (r >= {1'b0, den}) begin
            r    = r - {1'b0, den};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // Q60 product, truncated.
   function automatic logic [63:0] nau_qmul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] pr;
      pr = {64'd0, a} * {64'd0, b};
      return pr[123:60];
   endfunction

   // e^-f for f in [0,1] by its alternating series.
   function automatic logic [63:0] nau_exp_neg_frac(input logic [63:0] f);
      logic [63:0] sum;
      logic [63:0] term;
      sum  = ONE_Q;
      term = ONE_Q;
      for (int k = 1; k <= 40; k++) begin
         term = nau_udiv(nau_qmul(term, f), 64'(k));
         if ((k & 1) != 0) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      return sum;
   endfunction

   // e^-(m/d): fractional part by series, integer part by repeated 1/e.
   function automatic logic [63:0] nau_exp_neg_ratio(input logic [31:0] m,
                                                      input logic [31:0] d);
      logic [63:0] einv;
      logic [63:0] n;
      logic [63:0] r;
      logic [63:0] f;
      logic [63:0] v;
      einv = nau_exp_neg_frac(ONE_Q);
      n    = nau_udiv(64'(m), 64'(d));
      r    = 64'(m) - n * 64'(d);
      f    = nau_udiv(r << 52, 64'(d)) << 8;
      v    = nau_exp_neg_frac(f);
      for (int k = 0; 64'(k) < n; k++) begin
         v = nau_qmul(v, einv);
      end
      return v;
   endfunction

   // 1/d in Q60 for d above one.
   function automatic logic [63:0] nau_recip(input logic [63:0] d);
      logic [63:0] r;
      logic [63:0] q;
      r = ONE_Q;
      q = '0;
      if (d <= ONE_Q) begin
         return ONE_Q;
      end
      for (int k = 0; k < Q_FRAC; k++) begin
         r = r << 1;
         q = q << 1;
         if (r >= d) begin
            r    = r - d;
            q[0] = 1'b1;
         end
      end
      return q;
   endfunction

   // Q60 to Q12, rounding halves up.
   function automatic logic signed [DATA_WIDTH-1:0] nau_round_q12(input logic [63:0] v);
      logic [63:0] s;
      s = (v + (64'd1 << (Q_FRAC - 13))) >> (Q_FRAC - 12);
      return DATA_WIDTH'(s);
   endfunction

   // One table point: sigmoid or tanh at -8 + 16*i/depth, in Q4.12.
   function automatic logic signed [DATA_WIDTH-1:0] nau_table_entry(input logic is_tanh,
                                                                    input int   i,
                                                                    input int   depth);
      int                           num;
      logic [31:0]                  a;
      logic [63:0]                  q;
      logic [63:0]                  q2;
      logic signed [DATA_WIDTH-1:0] th;
      logic signed [DATA_WIDTH-1:0] sg;
      num = 16 * i - 8 * depth;
      a   = 32'((num < 0) ? -num : num);
      q   = nau_recip(ONE_Q + nau_exp_neg_ratio(a, 32'(depth)));
      q2  = nau_recip(ONE_Q + nau_exp_neg_ratio(a << 1, 32'(depth)));
      th  = nau_round_q12((q2 << 1) - ONE_Q);
      sg  = nau_round_q12((num >= 0) ? q : (ONE_Q - q));
      if (is_tanh) begin
         return (num >= 0) ? th : -th;
      end
      return sg;
   endfunction

endpackage

/* rtl/core/nau_front.sv */
`timescale 1ns / 1ps

module nau_front import nau_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  nau_req_type                  in_item,
   input  logic [MODE_WIDTH-1:0]        mode,
   input  logic signed [DATA_WIDTH-1:0] leak_slope,
   output logic                         mid_valid,
   output nau_mid_type                  mid
);

   localparam int IDX_W  = $clog2(TABLE_DEPTH + 1);
   localparam int PROD_W = DATA_WIDTH + IDX_W;

   // Constant sigmoid and tanh tables, TABLE_DEPTH+1 points each.
   logic signed [DATA_WIDTH-1:0] sig_rom  [TABLE_DEPTH+1];
   logic signed [DATA_WIDTH-1:0] tanh_rom [TABLE_DEPTH+1];

   for (genvar gi = 0; gi <= TABLE_DEPTH; gi++) begin : g_rom
      localparam logic signed [DATA_WIDTH-1:0] SIG_V  = nau_table_entry(1'b0, gi, TABLE_DEPTH);
      localparam logic signed [DATA_WIDTH-1:0] TANH_V = nau_table_entry(1'b1, gi, TABLE_DEPTH);
      assign sig_rom[gi]  = SIG_V;
      assign tanh_rom[gi] = TANH_V;
   end

   // Stage A: offset the sample, scale by the table depth, split index and fraction.
   logic [DATA_WIDTH-1:0] offset;
   logic [PROD_W-1:0]     pos;
   logic [IDX_W-1:0]      idx_raw;
   logic [IDX_W-1:0]      a_idx_in;

   assign offset   = {~in_item.sample[DATA_WIDTH-1], in_item.sample[DATA_WIDTH-2:0]};
   assign pos      = PROD_W'(offset) * PROD_W'(TABLE_DEPTH);
   assign idx_raw  = pos[PROD_W-1:DATA_WIDTH];
   assign a_idx_in = (idx_raw >= IDX_W'(TABLE_DEPTH)) ? IDX_W'(TABLE_DEPTH - 1) : idx_raw;

   logic                         a_valid_ff;
   logic signed [DATA_WIDTH-1:0] a_x_ff;
   logic                         a_last_ff;
   logic [MODE_WIDTH-1:0]        a_mode_ff;
   logic [IDX_W-1:0]             a_idx_ff;
   logic [DATA_WIDTH-1:0]        a_rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      a_x_ff    <= in_item.sample;
      a_last_ff <= in_item.last_in;
      a_mode_ff <= mode;
      a_idx_ff  <= a_idx_in;
      a_rem_ff  <= pos[DATA_WIDTH-1:0];
   end

   // Stage B: read both neighbor points and form the leaky product.
   logic [IDX_W-1:0]             idx_hi;
   logic                         use_tanh;
   logic signed [DATA_WIDTH-1:0] t0;
   logic signed [DATA_WIDTH-1:0] t1;
   nau_mid_type                  mid_in;

   assign idx_hi   = a_idx_ff + IDX_W'(1);
   assign use_tanh = (a_mode_ff == MODE_TANH);
   assign t0       = use_tanh ? tanh_rom[a_idx_ff] : sig_rom[a_idx_ff];
   assign t1       = use_tanh ? tanh_rom[idx_hi]   : sig_rom[idx_hi];

   always_comb begin
      mid_in.mode      = a_mode_ff;
      mid_in.last      = a_last_ff;
      mid_in.x         = a_x_ff;
      mid_in.t0        = t0;
      mid_in.diff      = DIFF_W'(t1) - DIFF_W'(t0);
      mid_in.rem       = a_rem_ff;
      mid_in.leak_prod = LEAK_W'(a_x_ff) * LEAK_W'(leak_slope);
   end

   logic        b_valid_ff;
   nau_mid_type mid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      mid_ff <= mid_in;
   end

   assign mid_valid = b_valid_ff;
   assign mid       = mid_ff;

endmodule

/* rtl/core/nau_back.sv */
`timescale 1ns / 1ps
`include "neural_activation_unit_top_assert.svh"

module nau_back import nau_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        mid_valid,
   input  nau_mid_type mid,
   output logic        rsp_valid,
   output nau_rsp_type rsp_item
);

   localparam int STEP_W    = MUL_W - DATA_WIDTH;
   localparam int LEAK_SH_W = LEAK_W - FRAC_BITS;

   // Stage C: scale the neighbor difference by the fraction.
   logic signed [MUL_W-1:0] mul_in;

   assign mul_in = MUL_W'(mid.diff) * MUL_W'($signed({1'b0, mid.rem}));

   logic                         c_valid_ff;
   logic [MODE_WIDTH-1:0]        c_mode_ff;
   logic                         c_last_ff;
   logic signed [DATA_WIDTH-1:0] c_x_ff;
   logic signed [DATA_WIDTH-1:0] c_t0_ff;
   logic signed [MUL_W-1:0]      c_mul_ff;
   logic signed [LEAK_W-1:0]     c_leak_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= mid_valid;
      end
   end

   always_ff @(posedge clock) begin
      c_mode_ff <= mid.mode;
      c_last_ff <= mid.last;
      c_x_ff    <= mid.x;
      c_t0_ff   <= mid.t0;
      c_mul_ff  <= mul_in;
      c_leak_ff <= mid.leak_prod;
   end

   // Stage D: floor shifts, interpolation sum, saturation and mode select.
   logic signed [STEP_W-1:0]     step;
   logic signed [STEP_W-1:0]     interp;
   logic signed [LEAK_SH_W-1:0]  leak_sh;
   logic signed [DATA_WIDTH-1:0] leak_sat;
   logic                         x_pos;
   logic signed [DATA_WIDTH-1:0] act;

   assign step    = c_mul_ff[MUL_W-1:DATA_WIDTH];
   assign interp  = STEP_W'(c_t0_ff) + step;
   assign leak_sh = c_leak_ff[LEAK_W-1:FRAC_BITS];
   assign x_pos   = !c_x_ff[DATA_WIDTH-1] && (c_x_ff != '0);

   always_comb begin
      if ((leak_sh[LEAK_SH_W-1:DATA_WIDTH-1] == '0) ||
          (leak_sh[LEAK_SH_W-1:DATA_WIDTH-1] == '1)) begin
         leak_sat = leak_sh[DATA_WIDTH-1:0];
      end else if (leak_sh[LEAK_SH_W-1]) begin
         leak_sat = ACT_MIN;
      end else begin
         leak_sat = ACT_MAX;
      end
   end

   always_comb begin
      unique case (c_mode_ff)
         MODE_RELU: begin
            act = x_pos ? c_x_ff : '0;
         end
         MODE_LEAKY: begin
            act = x_pos ? c_x_ff : leak_sat;
         end
         MODE_SIGMOID, MODE_TANH: begin
            act = interp[DATA_WIDTH-1:0];
         end
      endcase
   end

   logic        rsp_valid_ff;
   nau_rsp_type rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff.activated <= act;
      rsp_item_ff.last_out  <= c_last_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // A ReLU result is never negative.
   `NAU_ASSERT_NEXT(a_relu_nonneg, clock, reset, c_valid_ff && (c_mode_ff == MODE_RELU), !rsp_item.activated[DATA_WIDTH-1], "relu result negative")
   // Sigmoid interpolation stays between zero and one.
   `NAU_ASSERT_NEXT(a_sigmoid_range, clock, reset, c_valid_ff && (c_mode_ff == MODE_SIGMOID), !rsp_item.activated[DATA_WIDTH-1] && (rsp_item.activated <= SIG_ONE), "sigmoid result out of range")
   // Every item leaving stage C reaches the result port.
   `NAU_ASSERT_NEXT(a_stage_d_follows, clock, reset, c_valid_ff, rsp_valid, "item lost in final stage")

endmodule

/* rtl/core/neural_activation_unit_top.sv */
`timescale 1ns / 1ps
`include "neural_activation_unit_top_assert.svh"

// Element-wise activation unit for signed Q4.12 samples: ReLU, leaky ReLU,
// sigmoid or tanh, chosen by the mode register. A sample transfer happens on
// any clock edge with start high and busy low; busy is always low, so one
// sample can be taken every cycle. The result passes through four register
// stages to rsp_item, marked by rsp_valid for exactly one cycle, and must be
// taken then: the receiver cannot stall the unit. The stages are index
// computation, table read with the leaky product, the interpolation multiply,
// and the final shift, saturation and select. The sigmoid and tanh tables hold
// TABLE_DEPTH+1 points over [-8, 8] and are built as constants at elaboration.
// Registers are written through the csr_ port, which is always ready, and
// should only change while no sample is in flight.
module neural_activation_unit_top import nau_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  nau_req_type                req_item,
   output logic                       rsp_valid,
   output nau_rsp_type                rsp_item,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   // The pipeline never stalls, so a transfer is possible in every cycle.
   logic req_accept;

   assign busy       = 1'b0;
   assign req_accept = start && !busy;
   assign csr_ready  = 1'b1;

   // Configuration registers; unknown indexes are ignored.
   logic [MODE_WIDTH-1:0]        mode_ff;
   logic [MODE_WIDTH-1:0]        mode_in;
   logic signed [DATA_WIDTH-1:0] leak_slope_ff;
   logic signed [DATA_WIDTH-1:0] leak_slope_in;

   always_comb begin
      mode_in       = mode_ff;
      leak_slope_in = leak_slope_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MODE: begin
               mode_in = csr_wdata[MODE_WIDTH-1:0];
            end
            CSR_LEAK_SLOPE: begin
               leak_slope_in = csr_wdata[DATA_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_RESET;
         leak_slope_ff <= LEAK_SLOPE_RESET;
      end else begin
         mode_ff       <= mode_in;
         leak_slope_ff <= leak_slope_in;
      end
   end

   // Lookup half, then interpolation half.
   logic        mid_valid;
   nau_mid_type mid;

   nau_front #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_accept),
      .in_item    (req_item),
      .mode       (mode_ff),
      .leak_slope (leak_slope_ff),
      .mid_valid  (mid_valid),
      .mid        (mid)
   );

   nau_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_valid (mid_valid),
      .mid       (mid),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // A result strobe follows each transfer through stages A to D, unless reset intervened.
   `NAU_ASSERT(a_latency, clock, reset, rsp_valid == ($past(req_accept, 4) && !$past(reset, 1) && !$past(reset, 2) && !$past(reset, 3) && !$past(reset, 4)), "result strobe does not match transfer four cycles earlier")

endmodule
